// File: rtl/core/dsgs_pkg.sv
// Package: types, constants and state encoding for the DMA scatter-gather segmenter.
package dsgs_pkg;

  localparam int PAGE_BYTES_DEF = 4096;
  localparam int MSS_W          = 13;
  localparam int MAXSEG_W       = 8;
  localparam int COUNT_W        = 16;
  localparam int LEN_W          = 12;
  localparam int ADDR_W         = 32;
  localparam int ERR_W          = 32;
  localparam int APB_AW         = 3;
  localparam int APB_DW         = 32;

  localparam logic [MSS_W-1:0]    MSS_RST    = 13'd4096;
  localparam logic [MAXSEG_W-1:0] MAXSEG_RST = 8'd1;
  localparam int                  MIN_SEG    = 64;
  localparam logic [LEN_W-1:0]    MAX_FRAG   = 12'd2048;

  typedef enum logic [0:0] {
    REG_MSS    = 1'b0,
    REG_MAXSEG = 1'b1
  } reg_idx_t;

  typedef enum logic [0:0] {
    KIND_DESC = 1'b0,
    KIND_SUM  = 1'b1
  } result_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ONE,
    ST_SEG,
    ST_SUM
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   buffer_address;
    logic [LEN_W-1:0]    buffer_length;
    logic                last_buffer;
    logic [MAXSEG_W-1:0] segment_limit;
  } in_item_t;

  typedef struct packed {
    logic                result_kind;
    logic [ADDR_W-1:0]   segment_address;
    logic [MSS_W-1:0]    segment_length;
    logic [MAXSEG_W-1:0] segment_index;
    logic [COUNT_W-1:0]  packet_segments;
    logic [ERR_W-1:0]    too_big_errors;
    logic                last_result;
  } out_item_t;

endpackage

// File: rtl/core/dma_scatter_gather_segmenter.sv
// Top level: DMA scatter-gather segmenter with page split and segment limit.
// Each accepted fragment passes a setup state, then steps once per segment through a
// shared min/add unit that cuts the next piece at the page edge or the maximum segment
// size, then a closing step once no bytes remain; pieces past the limit are consumed with
// no output, and the input stays stalled until the fragment is through. A single-fragment
// packet inside one page goes out as one segment with no closing step; a packet with a
// zero limit skips the segment steps. The last fragment adds a step for the summary,
// and every result waits while the output is stalled. The input is stalled whenever the
// sequencer is not idle. The result register lets the next fragment be taken while the
// last result still waits for transfer.
module dma_scatter_gather_segmenter
  import dsgs_pkg::*;
#(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int PGW = $clog2(PAGE_BYTES);
  localparam int CW  = (PGW + 1 > MSS_W) ? PGW + 1 : MSS_W;
  localparam int SW  = CW + 1;

  state_t                state_r, state_nxt;
  logic [MSS_W-1:0]      mss_cfg_r, mss_cfg_nxt;
  logic [MAXSEG_W-1:0]   maxseg_r, maxseg_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [MAXSEG_W-1:0]   limit_r, limit_nxt;
  logic                  first_r, first_nxt;
  logic [ERR_W-1:0]      rej_r, rej_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r, out_nxt;
  logic [ADDR_W-1:0]     addr_r, addr_nxt;
  logic [LEN_W-1:0]      rem_r, rem_nxt;
  logic                  last_r, last_nxt;
  logic                  started_r, started_nxt;
  logic [CW-1:0]         mss_r, mss_nxt;

  logic                  in_acc;
  logic                  cfg_wr;
  reg_idx_t              cfg_idx;
  logic                  ld;
  logic [PGW-1:0]        off;
  logic [PGW:0]          room;
  logic [SW-1:0]         end_sum;
  logic                  one_page;
  logic [LEN_W-1:0]      seg_t;
  logic                  emit;
  logic [COUNT_W:0]      count_inc;
  logic [CW-1:0]         mss_ext;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign cfg_idx   = reg_idx_t'(paddr[2]);
  assign ld        = !out_valid_r || !out_stall;

  always_comb begin
    case (cfg_idx)
      REG_MSS:    prdata = APB_DW'(mss_cfg_r);
      REG_MAXSEG: prdata = APB_DW'(maxseg_r);
      default:    prdata = '0;
    endcase
  end

  // shared segment unit: page offset, room to page edge, next piece length
  always_comb begin
    off       = addr_r[PGW-1:0];
    room      = (PGW+1)'(PAGE_BYTES) - {1'b0, off};
    end_sum   = SW'(off) + SW'(rem_r);
    if (rem_r == '0) begin
      one_page = (off != '0);
    end else begin
      one_page = (end_sum <= SW'(PAGE_BYTES));
    end
    seg_t = rem_r;
    if (mss_r < CW'(seg_t)) begin
      seg_t = mss_r[LEN_W-1:0];
    end
    if (CW'(room) < CW'(seg_t)) begin
      seg_t = room[LEN_W-1:0];
    end
    emit      = (count_r < COUNT_W'(limit_r));
    count_inc = {1'b0, count_r} + 1'b1;
    mss_ext   = CW'(mss_cfg_r);
  end

  always_comb begin
    state_nxt     = state_r;
    mss_cfg_nxt   = mss_cfg_r;
    maxseg_nxt    = maxseg_r;
    count_nxt     = count_r;
    limit_nxt     = limit_r;
    first_nxt     = first_r;
    rej_nxt       = rej_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    addr_nxt      = addr_r;
    rem_nxt       = rem_r;
    last_nxt      = last_r;
    started_nxt   = started_r;
    mss_nxt       = mss_r;

    if (cfg_wr) begin
      case (cfg_idx)
        REG_MSS:    mss_cfg_nxt = pwdata[MSS_W-1:0];
        REG_MAXSEG: maxseg_nxt  = pwdata[MAXSEG_W-1:0];
        default:    ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          addr_nxt    = in_data.buffer_address;
          rem_nxt     = (in_data.buffer_length > MAX_FRAG) ? MAX_FRAG : in_data.buffer_length;
          last_nxt    = in_data.last_buffer;
          started_nxt = first_r;
          if (first_r) begin
            limit_nxt = (in_data.segment_limit != '0) ? in_data.segment_limit : maxseg_r;
            count_nxt = '0;
            first_nxt = 1'b0;
          end
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (mss_ext < CW'(MIN_SEG)) begin
          mss_nxt = CW'(MIN_SEG);
        end else if (mss_ext > CW'(PAGE_BYTES)) begin
          mss_nxt = CW'(PAGE_BYTES);
        end else begin
          mss_nxt = mss_ext;
        end
        if (limit_r == '0) begin
          state_nxt = last_r ? ST_SUM : ST_IDLE;
        end else if (started_r && last_r && one_page) begin
          state_nxt = ST_ONE;
        end else begin
          state_nxt = ST_SEG;
        end
      end
      ST_ONE: begin
        if (ld) begin
          out_valid_nxt           = 1'b1;
          out_nxt                 = '0;
          out_nxt.result_kind     = KIND_DESC;
          out_nxt.segment_address = addr_r;
          out_nxt.segment_length  = MSS_W'(rem_r);
          out_nxt.too_big_errors  = rej_r;
          count_nxt               = COUNT_W'(1);
          state_nxt               = ST_SUM;
        end
      end
      ST_SEG: begin
        if (rem_r == '0) begin
          state_nxt = last_r ? ST_SUM : ST_IDLE;
        end else if (!emit || ld) begin
          if (emit) begin
            out_valid_nxt           = 1'b1;
            out_nxt                 = '0;
            out_nxt.result_kind     = KIND_DESC;
            out_nxt.segment_address = addr_r;
            out_nxt.segment_length  = MSS_W'(seg_t);
            out_nxt.segment_index   = count_r[MAXSEG_W-1:0];
            out_nxt.too_big_errors  = rej_r;
            // later pieces are dropped once the limit is reached
            out_nxt.last_result     = !last_r &&
                                      ((rem_r == seg_t) || (count_inc >= (COUNT_W+1)'(limit_r)));
          end
          if (count_r != '1) begin
            count_nxt = count_inc[COUNT_W-1:0];
          end
          addr_nxt = addr_r + ADDR_W'(seg_t);
          rem_nxt  = rem_r - seg_t;
        end
      end
      ST_SUM: begin
        if (ld) begin
          out_valid_nxt       = 1'b1;
          out_nxt             = '0;
          out_nxt.result_kind = KIND_SUM;
          out_nxt.last_result = 1'b1;
          if (count_r > COUNT_W'(limit_r)) begin
            rej_nxt                 = rej_r + 1'b1;
            out_nxt.packet_segments = '0;
          end else begin
            out_nxt.packet_segments = count_r;
          end
          out_nxt.too_big_errors = rej_nxt;
          first_nxt              = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mss_cfg_r   <= MSS_RST;
      maxseg_r    <= MAXSEG_RST;
      count_r     <= '0;
      limit_r     <= '0;
      first_r     <= 1'b1;
      rej_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mss_cfg_r   <= mss_cfg_nxt;
      maxseg_r    <= maxseg_nxt;
      count_r     <= count_nxt;
      limit_r     <= limit_nxt;
      first_r     <= first_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r     <= out_nxt;
    addr_r    <= addr_nxt;
    rem_r     <= rem_nxt;
    last_r    <= last_nxt;
    started_r <= started_nxt;
    mss_r     <= mss_nxt;
  end

  a_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEG && rem_r != '0 && (!emit || ld)) |=> (rem_r < $past(rem_r)))
    else $error("segment step did not consume bytes");

  a_desc_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.result_kind == KIND_DESC) |-> (out_r.segment_index < limit_r))
    else $error("descriptor index at or above segment limit");

  a_sum_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.result_kind == KIND_SUM) |-> out_r.last_result)
    else $error("summary not marked as last result");

  a_rej_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && rej_r != $past(rej_r)) |->
      (rej_r == $past(rej_r) + 1'b1 && $past(state_r) == ST_SUM))
    else $error("error counter changed outside a summary");

endmodule
